FILE: rtl/dsr_pkg.sv
// Shared constants for the dielectric refract/Schlick scatter pipeline.
// No dependencies; used by the top level.
package dsr_pkg;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int PERP_LIM_LOG = 24;
endpackage

FILE: rtl/dsr_isqrt.sv
// Pipelined floor integer square root, one result bit per register stage.
// Standalone; instanced by dielectric_refract_schlick_top.
module dsr_isqrt #(
  parameter int IW = 29,
  localparam int RB = (IW + 1) / 2
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [IW-1:0] val,
  output logic [RB-1:0] root
);
  localparam int RW = 2 * RB + 1;

  logic [RW-1:0] rem_r  [RB];
  logic [RB-1:0] root_r [RB];

  for (genvar j = 0; j < RB; j++) begin : g_step
    localparam int B = RB - 1 - j;
    logic [RW-1:0] rem_in;
    logic [RW-1:0] trial;
    logic [RB-1:0] root_in;
    if (j == 0) begin : g_first
      assign rem_in  = RW'(val);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end
    assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_in >= trial) begin
          rem_r[j]  <= rem_in - trial;
          root_r[j] <= root_in | (RB'(1) << B);
        end else begin
          rem_r[j]  <= rem_in;
          root_r[j] <= root_in;
        end
      end
    end
  end

  assign root = root_r[RB-1];
endmodule

FILE: rtl/dielectric_refract_schlick_top.sv
// Dielectric scatter: Snell refraction or mirror by Schlick reflectance, deep pipeline.
// Depends on dsr_pkg and dsr_isqrt.
//
// channel  | ports                                         | dir
// input    | in_valid/in_ready, in_x..z, in_norm_x..z,     | in
//          | in_refraction_ratio, in_random_value          |
// result   | out_valid/out_ready, out_x..z, out_reflected  | out
//
// One transaction per cycle while the pipe advances; the pipeline depth is
// dominated by the bit-per-stage square root of the parallel component. The
// whole pipe advances together: it holds when the output register is full
// and out_ready is low.
// Synchronous active-low reset clears the valid bits only.
module dielectric_refract_schlick_top #(
  parameter int FRACTION_BITS = dsr_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic        [15:0] in_refraction_ratio,
  input  logic        [15:0] in_random_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic               out_reflected
);
  localparam int FB = FRACTION_BITS;
  localparam longint ONE_L = 64'sd1 <<< FB;
  localparam longint HALF_L = 64'sd1 <<< (FB - 1);
  localparam longint PLIM_L = 64'sd1 <<< dsr_pkg::PERP_LIM_LOG;
  localparam int QB = FB + 1;
  localparam int SW = (36 - FB > FB + 3) ? 36 - FB : FB + 3;
  localparam int DW = ((FB > 16) ? FB : 16) + 1;
  localparam int EW = DW + 1;
  localparam int NB = DW + FB;
  localparam int CMPW = (NB > EW + QB) ? NB : EW + QB;
  localparam int AW = ((SW + 17 - FB > 16) ? SW + 17 - FB : 16) + 1;
  localparam int RAW = AW + 17;
  localparam int PLW = dsr_pkg::PERP_LIM_LOG + 2;
  localparam int PSQW = 2 * PLW;
  localparam int PPW = PSQW - FB + 3;
  localparam int RMW = (PPW > FB + 2) ? PPW : FB + 2;
  localparam int IW1 = 2 * FB + 1;
  localparam int IW2 = RMW + FB;
  localparam int RB2 = (IW2 + 1) / 2;
  localparam int MW = ((SW + 18 - FB > 16) ? SW + 18 - FB : 16) + 1;
  localparam int PNW = RB2 + 17;
  localparam int RRW = ((PNW - FB + 1 > PLW) ? PNW - FB + 1 : PLW) + 1;
  localparam int OW = (MW > RRW) ? MW : RRW;
  localparam int T1W = ((16 + QB > 2 * FB + 1) ? 16 + QB : 2 * FB + 1) + 1;
  localparam int T2W = QB + 18;
  localparam int KM = FB + 8;
  localparam int KR = 12 + RB2;
  localparam int KF = KR;
  localparam int KO = KF + 1;

  typedef struct packed {
    logic [2:0][15:0] d;
    logic [2:0][15:0] n;
    logic [15:0]      ratio;
    logic [15:0]      rv;
  } ray_t;

  logic adv;
  logic v_r [1:KO];
  ray_t ray_nxt;
  ray_t inp_r [1:KF];

  assign adv       = !v_r[KO] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v_r[KO];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= KO; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= KO; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_comb begin
    ray_nxt.d     = {in_z, in_y, in_x};
    ray_nxt.n     = {in_norm_z, in_norm_y, in_norm_x};
    ray_nxt.ratio = in_refraction_ratio;
    ray_nxt.rv    = in_random_value;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inp_r[1] <= ray_nxt;
      for (int k = 2; k <= KF; k++) inp_r[k] <= inp_r[k-1];
    end
  end

  // stage 2: dot products, Schlick quotient operands
  logic signed [31:0] prod_r [3];
  logic signed [DW:0] dtmp_nxt;
  logic [DW-1:0]      diff_r;
  logic [EW-1:0]      den_r;

  assign dtmp_nxt = (DW+1)'(ONE_L) - (DW+1)'($signed({1'b0, inp_r[1].ratio}));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        prod_r[i] <= $signed(inp_r[1].d[i]) * $signed(inp_r[1].n[i]);
      diff_r <= dtmp_nxt < 0 ? DW'(-dtmp_nxt) : DW'(dtmp_nxt);
      den_r  <= EW'(ONE_L) + EW'(inp_r[1].ratio);
    end
  end

  // stage 3: cosine and one minus cosine
  logic signed [33:0]   dsum_nxt;
  logic signed [SW-1:0] dn_nxt, cneg_nxt, c_nxt;
  logic signed [SW-1:0] dn_r, c_r, t_r;

  always_comb begin
    dsum_nxt = 34'(prod_r[0]) + 34'(prod_r[1]) + 34'(prod_r[2]);
    dn_nxt   = SW'((dsum_nxt + 34'(HALF_L)) >>> FB);
    cneg_nxt = -dn_nxt;
    c_nxt    = (cneg_nxt > SW'(ONE_L)) ? SW'(ONE_L) : cneg_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_r <= dn_nxt;
      c_r  <= c_nxt;
      t_r  <= SW'(ONE_L) - c_nxt;
    end
  end

  // r0 quotient: restoring division, one quotient bit per stage
  logic [NB-1:0] dv_rem_r [QB];
  logic [EW-1:0] dv_den_r [QB];
  logic [QB-1:0] dv_q_r   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic [NB-1:0]   rem_in;
    logic [EW-1:0]   den_in;
    logic [QB-1:0]   q_in;
    logic [CMPW-1:0] sh;
    if (j == 0) begin : g_first
      assign rem_in = {diff_r, {FB{1'b0}}};
      assign den_in = den_r;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = dv_rem_r[j-1];
      assign den_in = dv_den_r[j-1];
      assign q_in   = dv_q_r[j-1];
    end
    assign sh = CMPW'(den_in) << B;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den_r[j] <= den_in;
        if (CMPW'(rem_in) >= sh) begin
          dv_rem_r[j] <= NB'(CMPW'(rem_in) - sh);
          dv_q_r[j]   <= q_in | (QB'(1) << B);
        end else begin
          dv_rem_r[j] <= rem_in;
          dv_q_r[j]   <= q_in;
        end
      end
    end
  end

  // stage 4: squares and normal products
  logic signed [2*SW-1:0]  cc_r;
  logic [2*QB-1:0]         tt_r;
  logic signed [SW+15:0]   cn_r  [3];
  logic signed [SW+15:0]   dnn_r [3];
  logic                    tbig_d [4:FB+6];
  logic [QB-1:0]           t_d [4:7];

  always_ff @(posedge clk) begin
    if (adv) begin
      cc_r <= c_r * c_r;
      tt_r <= t_r[QB-1:0] * t_r[QB-1:0];
      for (int i = 0; i < 3; i++) begin
        cn_r[i]  <= c_r * $signed(inp_r[3].n[i]);
        dnn_r[i] <= dn_r * $signed(inp_r[3].n[i]);
      end
      tbig_d[4] <= t_r >= SW'(ONE_L);
      for (int k = 5; k <= FB + 6; k++) tbig_d[k] <= tbig_d[k-1];
      t_d[4] <= t_r[QB-1:0];
      for (int k = 5; k <= 7; k++) t_d[k] <= t_d[k-1];
    end
  end

  // stage 5: sine squared, Schlick power, perpendicular sum, mirror
  logic signed [2*SW-1:0] rcc_nxt;
  logic signed [2*SW:0]   sdiff_nxt;
  logic [QB-1:0]          sin2_r, p2_r;
  logic signed [AW-1:0]   a_r [3];
  logic signed [MW-1:0]   mr_d [5:KF][3];
  logic signed [SW+15:0]  rcn_nxt [3];
  logic signed [SW+16:0]  x2_nxt [3];
  logic signed [SW+16:0]  rm_nxt [3];

  always_comb begin
    rcc_nxt   = (2*SW)'((cc_r + (2*SW)'(HALF_L)) >>> FB);
    sdiff_nxt = (2*SW+1)'(ONE_L) - (2*SW+1)'(rcc_nxt);
    for (int i = 0; i < 3; i++) begin
      rcn_nxt[i] = (SW+16)'((cn_r[i] + (SW+16)'(HALF_L)) >>> FB);
      x2_nxt[i]  = (SW+17)'(dnn_r[i]) <<< 1;
      rm_nxt[i]  = (SW+17)'((x2_nxt[i] + (SW+17)'(HALF_L)) >>> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sin2_r <= (sdiff_nxt < 0) ? '0 : QB'(sdiff_nxt);
      p2_r   <= QB'((tt_r + (2*QB)'(HALF_L)) >> FB);
      for (int i = 0; i < 3; i++) begin
        a_r[i]     <= AW'($signed(inp_r[4].d[i])) + AW'(rcn_nxt[i]);
        mr_d[5][i] <= MW'($signed(inp_r[4].d[i])) - MW'(rm_nxt[i]);
      end
      for (int k = 6; k <= KF; k++) mr_d[k] <= mr_d[k-1];
    end
  end

  logic [QB-1:0] s_w;

  dsr_isqrt #(.IW(IW1)) u_sin_sqrt (
    .clk  (clk),
    .adv  (adv),
    .val  ({sin2_r, {FB{1'b0}}}),
    .root (s_w)
  );

  // stages 6 to 10: Schlick power chain and refracted perpendicular part
  logic [2*QB-1:0]        p2sq_r, p4t_r;
  logic [QB-1:0]          p4_r;
  logic [QB-1:0]          p5_d [9:FB+5];
  logic signed [RAW-1:0]  ra_r [3];
  logic signed [RAW-1:0]  rp_nxt [3];
  logic signed [PLW-1:0]  perp_d [7:KR-1][3];
  logic signed [PSQW-1:0] psq_r [3];
  logic signed [PPW-1:0]  pp_nxt, pp_r;
  logic signed [RMW:0]    remv_nxt;
  logic [RMW-1:0]         rem_r;

  always_comb begin
    for (int i = 0; i < 3; i++) rp_nxt[i] = RAW'((ra_r[i] + RAW'(HALF_L)) >>> FB);
    pp_nxt = '0;
    for (int i = 0; i < 3; i++)
      pp_nxt = pp_nxt + PPW'((psq_r[i] + PSQW'(HALF_L)) >>> FB);
    remv_nxt = (RMW+1)'(ONE_L) - (RMW+1)'(pp_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2sq_r <= p2_r * p2_r;
      p4_r   <= QB'((p2sq_r + (2*QB)'(HALF_L)) >> FB);
      p4t_r  <= p4_r * t_d[7];
      p5_d[9] <= QB'((p4t_r + (2*QB)'(HALF_L)) >> FB);
      for (int k = 10; k <= FB + 5; k++) p5_d[k] <= p5_d[k-1];
      for (int i = 0; i < 3; i++) begin
        ra_r[i] <= $signed({1'b0, inp_r[5].ratio}) * a_r[i];
        if (rp_nxt[i] > RAW'(PLIM_L))       perp_d[7][i] <= PLW'(PLIM_L);
        else if (rp_nxt[i] < -RAW'(PLIM_L)) perp_d[7][i] <= -PLW'(PLIM_L);
        else                                perp_d[7][i] <= PLW'(rp_nxt[i]);
        psq_r[i] <= perp_d[7][i] * perp_d[7][i];
      end
      for (int k = 8; k <= KR - 1; k++) perp_d[k] <= perp_d[k-1];
      pp_r  <= pp_nxt;
      rem_r <= (remv_nxt < 0) ? RMW'(-remv_nxt) : RMW'(remv_nxt);
    end
  end

  // reflectance and mirror decision
  logic [2*QB-1:0] qq_r;
  logic [QB:0]     r0_r, r0d_r, refl_r;
  logic [2*QB:0]   omr_r;
  logic [QB-1:0]   s_d_r;
  logic            mir_d [KM:KF];
  logic            t1_nxt, t2_nxt;

  always_comb begin
    t1_nxt = (T1W'(inp_r[KM-1].ratio) * T1W'(s_d_r)) > (T1W'(1) << (2 * FB));
    t2_nxt = (T2W'(refl_r) << 16) > (T2W'(inp_r[KM-1].rv) << FB);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qq_r   <= dv_q_r[QB-1] * dv_q_r[QB-1];
      r0_r   <= (QB+1)'((qq_r + (2*QB)'(HALF_L)) >> FB);
      omr_r  <= ((QB+1)'(ONE_L) - r0_r) * p5_d[FB+5];
      r0d_r  <= r0_r;
      refl_r <= tbig_d[FB+6] ? (QB+1)'(ONE_L)
                             : r0d_r + (QB+1)'((omr_r + (2*QB+1)'(HALF_L)) >> FB);
      s_d_r  <= s_w;
      mir_d[KM] <= t1_nxt || t2_nxt;
      for (int k = KM + 1; k <= KF; k++) mir_d[k] <= mir_d[k-1];
    end
  end

  // parallel part and refracted direction
  logic [RB2-1:0]        par_w;
  logic signed [PNW-1:0] pn_r [3];
  logic signed [RRW-1:0] rr_r [3];

  dsr_isqrt #(.IW(IW2)) u_par_sqrt (
    .clk  (clk),
    .adv  (adv),
    .val  ({rem_r, {FB{1'b0}}}),
    .root (par_w)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pn_r[i] <= $signed({1'b0, par_w}) * $signed(inp_r[KR-2].n[i]);
        rr_r[i] <= RRW'(perp_d[KR-1][i]) - RRW'((pn_r[i] + PNW'(HALF_L)) >>> FB);
      end
    end
  end

  // output register
  function automatic logic [15:0] sat16(input logic signed [OW-1:0] v);
    if (v > OW'(32767))  return 16'h7FFF;
    if (v < OW'(-32768)) return 16'h8000;
    return v[15:0];
  endfunction

  logic signed [OW-1:0] sel_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      sel_nxt[i] = mir_d[KF] ? OW'(mr_d[KF][i]) : OW'(rr_r[i]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x         <= sat16(sel_nxt[0]);
      out_y         <= sat16(sel_nxt[1]);
      out_z         <= sat16(sel_nxt[2]);
      out_reflected <= mir_d[KF];
    end
  end
endmodule

FILE: sim/tb_top.sv
// Testbench for dielectric_refract_schlick_top: directed and random rays, checked
// against an in-bench fixed-point scatter predictor. Depends on dsr_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  localparam int FB = dsr_pkg::FRACTION_BITS_DEF;
  localparam longint ONE_Q = longint'(1) << FB;
  localparam longint HALF_Q = longint'(1) << (FB - 1);
  localparam longint PERP_LIM = longint'(1) << dsr_pkg::PERP_LIM_LOG;
  localparam int LATENCY = 80;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               refl;
  } scatter_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] in_x = 0, in_y = 0, in_z = 0;
  logic signed [15:0] in_norm_x = 0, in_norm_y = 0, in_norm_z = 0;
  logic [15:0] in_refraction_ratio = 0, in_random_value = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] out_x, out_y, out_z;
  logic out_reflected;

  scatter_t expected_rays[$];
  int errors = 0;
  bit out_idle_en = 1;
  bit in_idle_en = 1;
  longint cycles = 0;

  dielectric_refract_schlick_top u_top (.*);

  always #6 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -1 - ((-1 - v) >>> s);
  endfunction

  function automatic longint qround(longint v);
    return floor_shift(v + HALF_Q, FB);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic scatter_t scatter_ray(logic signed [15:0] dx, dy, dz, nx, ny, nz,
                                           logic [15:0] ratio_in, logic [15:0] rand_in);
    longint d[3], n[3], r[3], perp[3];
    longint ratio, rv, dn, c, sin2, s, t, refl, diff, q, r0, p, pp, rem, par;
    bit mirror;
    scatter_t res;
    d[0] = dx; d[1] = dy; d[2] = dz;
    n[0] = nx; n[1] = ny; n[2] = nz;
    ratio = ratio_in;
    rv = rand_in;
    dn = qround(d[0] * n[0] + d[1] * n[1] + d[2] * n[2]);
    c = -dn;
    if (c > ONE_Q) c = ONE_Q;
    t = ONE_Q - c;
    if (t >= ONE_Q) begin
      sin2 = (c < -ONE_Q) ? 0 : ONE_Q - qround(c * c);
      refl = ONE_Q;
    end else begin
      diff = ONE_Q - ratio;
      if (diff < 0) diff = -diff;
      q = (diff << FB) / (ONE_Q + ratio);
      r0 = qround(q * q);
      p = qround(t * t);
      p = qround(p * p);
      p = qround(p * t);
      refl = r0 + qround((ONE_Q - r0) * p);
      sin2 = ONE_Q - qround(c * c);
    end
    if (sin2 < 0) sin2 = 0;
    s = int_sqrt(sin2 << FB);
    mirror = (ratio * s > (ONE_Q << FB)) || ((refl << 16) > (rv << FB));
    if (mirror) begin
      for (int i = 0; i < 3; i++) r[i] = d[i] - qround(2 * dn * n[i]);
    end else begin
      pp = 0;
      for (int i = 0; i < 3; i++) begin
        perp[i] = clip(qround(ratio * (d[i] + qround(c * n[i]))), -PERP_LIM, PERP_LIM);
        pp += qround(perp[i] * perp[i]);
      end
      rem = ONE_Q - pp;
      if (rem < 0) rem = -rem;
      par = int_sqrt(rem << FB);
      for (int i = 0; i < 3; i++) r[i] = perp[i] - qround(par * n[i]);
    end
    res.x = 16'(clip(r[0], -32768, 32767));
    res.y = 16'(clip(r[1], -32768, 32767));
    res.z = 16'(clip(r[2], -32768, 32767));
    res.refl = mirror;
    return res;
  endfunction

  task automatic send_ray(logic signed [15:0] dx, dy, dz, nx, ny, nz,
                          logic [15:0] ratio, logic [15:0] rv);
    int gap;
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    in_x <= dx; in_y <= dy; in_z <= dz;
    in_norm_x <= nx; in_norm_y <= ny; in_norm_z <= nz;
    in_refraction_ratio <= ratio; in_random_value <= rv;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    expected_rays.push_back(scatter_ray(dx, dy, dz, nx, ny, nz, ratio, rv));
    @(negedge clk);
  endtask

  // out_ready: random stall bursts
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (out_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        gap = $urandom_range(1, 18);
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    scatter_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rays.size() == 0) begin
        $display("%0t: unexpected transaction x=%0d y=%0d z=%0d refl=%0b", $time,
                 out_x, out_y, out_z, out_reflected);
        errors++;
      end else begin
        exp_r = expected_rays.pop_front();
        if (out_x !== exp_r.x || out_y !== exp_r.y || out_z !== exp_r.z ||
            out_reflected !== exp_r.refl) begin
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d refl=%0b",
                   $time, exp_r.x, exp_r.y, exp_r.z, exp_r.refl,
                   " actual x=%0d y=%0d z=%0d refl=%0b",
                   out_x, out_y, out_z, out_reflected);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [15:0] unit_comp();
    return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
  endfunction

  task automatic test_directed();
    logic signed [15:0] o = 16'sd16384;
    logic signed [15:0] mo = -16'sd16384;
    send_ray(0, mo, 0, 0, o, 0, 16'd10923, 16'd0);
    send_ray(0, mo, 0, 0, o, 0, 16'd10923, 16'hFFFF);
    send_ray(11585, -11585, 0, 0, o, 0, 16'd24576, 16'hFFFF);
    send_ray(11585, -11585, 0, 0, o, 0, 16'd10923, 16'h8000);
    send_ray(0, o, 0, 0, o, 0, 16'd10923, 16'h1234);
    send_ray(0, 16'sh7FFF, 0, 0, 16'sh7FFF, 0, 16'd16384, 16'hFFFF);
    send_ray(0, mo, 0, 0, o, 0, 16'd0, 16'hFFFF);
    send_ray(0, mo, 0, 0, o, 0, 16'd1, 16'hFFFF);
    send_ray(0, mo, 0, 0, o, 0, 16'hFFFF, 16'hFFFF);
    send_ray(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
             16'hFFFF, 16'h0000);
    send_ray(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
             16'hFFFF, 16'hFFFF);
    send_ray(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
             16'h4000, 16'hFFFF);
    send_ray(5000, -15000, 3000, 0, o, 0, 16'hFFFF, 16'hFFFF);
    send_ray(-9000, -9000, 9000, 0, 0, o, 16'd30000, 16'd100);
  endtask

  task automatic test_random(int count, bit full_range);
    logic signed [15:0] dx, dy, dz, nx, ny, nz;
    for (int i = 0; i < count; i++) begin
      if (full_range || $urandom_range(0, 9) == 0) begin
        dx = 16'($urandom); dy = 16'($urandom); dz = 16'($urandom);
        nx = 16'($urandom); ny = 16'($urandom); nz = 16'($urandom);
      end else begin
        dx = unit_comp(); dy = unit_comp(); dz = unit_comp();
        nx = unit_comp(); ny = unit_comp(); nz = unit_comp();
      end
      send_ray(dx, dy, dz, nx, ny, nz, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_directed();
    test_random(450, 0);
    test_random(250, 1);
    in_idle_en = 0;
    out_idle_en = 0;
    test_random(250, 0);
    in_valid <= 0;
    while (expected_rays.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/dsr_pkg.sv
rtl/dsr_isqrt.sv
rtl/dielectric_refract_schlick_top.sv
sim/tb_top.sv
